// ===== hw/rtl/bdq_pkg.sv =====
// Shared types and codes for the bounded deque with reverse.
// Used by bdq_ptr and bounded_deque_with_reverse; no dependencies.
package bdq_pkg;

  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_REVERSE    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
  } out_word_t;

  // Control from the pointer unit to the sequencer for one request.
  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    status_t status;
  } ptr_ctl_t;

endpackage

// ===== hw/rtl/bdq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bdq_ptr.sv =====
// Ring pointer unit: front index, entry count and orientation flag.
// Decodes a request into store addresses and status. Depends on bdq_pkg.
module bdq_ptr #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  input  bdq_pkg::func_t           func,
  output bdq_pkg::ptr_ctl_t        ctl,
  output logic [$clog2(DEPTH)-1:0] waddr,
  output logic [$clog2(DEPTH)-1:0] raddr
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;

  logic          full, empty, at_head;
  logic [AW-1:0] front_dec, front_inc, back_slot, tail_slot;
  logic [SW-1:0] sum_back, sum_tail;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);

  // Wrap modulo DEPTH: the sum stays below twice the depth.
  assign sum_back  = SW'(front_r) + SW'(count_r);
  assign sum_tail  = sum_back - SW'(1);
  assign back_slot = (sum_back >= SW'(DEPTH)) ? AW'(sum_back - SW'(DEPTH)) : AW'(sum_back);
  assign tail_slot = (sum_tail >= SW'(DEPTH)) ? AW'(sum_tail - SW'(DEPTH)) : AW'(sum_tail);

  always_comb begin
    ctl       = '{wr_en: 1'b0, rd_en: 1'b0, status: bdq_pkg::STAT_DONE};
    front_nxt = front_r;
    count_nxt = count_r;
    rev_nxt   = rev_r;
    waddr     = back_slot;
    raddr     = front_r;
    at_head   = 1'b0;
    case (func)
      bdq_pkg::FN_PUSH_FRONT, bdq_pkg::FN_PUSH_BACK: begin
        at_head = (func == bdq_pkg::FN_PUSH_FRONT) ? !rev_r : rev_r;
        if (full) begin
          ctl.status = bdq_pkg::STAT_FULL;
        end else begin
          ctl.wr_en = 1'b1;
          count_nxt = count_r + CW'(1);
          if (at_head) begin
            waddr     = front_dec;
            front_nxt = front_dec;
          end
        end
      end
      bdq_pkg::FN_POP_FRONT, bdq_pkg::FN_POP_BACK: begin
        at_head = (func == bdq_pkg::FN_POP_FRONT) ? !rev_r : rev_r;
        if (empty) begin
          ctl.status = bdq_pkg::STAT_EMPTY;
        end else begin
          ctl.rd_en = 1'b1;
          count_nxt = count_r - CW'(1);
          if (at_head) begin
            front_nxt = front_inc;
          end else begin
            raddr = tail_slot;
          end
        end
      end
      bdq_pkg::FN_REVERSE: begin
        rev_nxt = !rev_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (cmd_valid) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

endmodule

// ===== hw/rtl/bounded_deque_with_reverse.sv =====
// Top level of the bounded deque with reverse: sequencer and output register.
// Depends on bdq_pkg, bdq_ptr and bdq_ram.
//
// Usage:
//   in_data carries func and push_value; out_data returns pop_value and status.
//   Both channels move one word per cycle where valid and ready are both high.
//   Every request word yields exactly one result word, in request order.
// Flow:
//   Pushes, reverse, unused codes and refused requests: result is registered
//   at the accept edge, one word per cycle while the receiver keeps up.
//   A successful pop reads the store at the accept edge; the output register
//   takes the data in the read state. No new word is taken meanwhile.
//   The store is one 32-bit RAM of DEPTH entries; pointers sit in flops.
// Reset:
//   rst_n (synchronous, active low) empties the queue and clears orientation
//   and the output valid flag. Store contents are not cleared; no pass is run.
// Stall:
//   A result waits in the output register while out_ready is low; in_ready
//   stays high only if that register frees up at the same edge.
module bounded_deque_with_reverse #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bdq_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bdq_pkg::out_word_t  out_data
);

  localparam int AW = $clog2(DEPTH);

  bdq_pkg::fsm_t      state_r, state_nxt;
  bdq_pkg::ptr_ctl_t  ctl;
  bdq_pkg::out_word_t out_data_r;
  logic               out_valid_r;
  logic               in_acc, out_take, pop_go;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        rdata;

  assign out_take = out_valid_r && out_ready;
  assign in_acc   = in_valid && in_ready;
  assign pop_go   = in_acc && ctl.rd_en;

  bdq_ptr #(
    .DEPTH(DEPTH)
  ) u_ptr (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(in_acc),
    .func     (bdq_pkg::func_t'(in_data.func)),
    .ctl      (ctl),
    .waddr    (waddr),
    .raddr    (raddr)
  );

  bdq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (in_acc && ctl.wr_en),
    .waddr(waddr),
    .wdata(in_data.push_value),
    .re   (pop_go),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdq_pkg::S_IDLE: begin
        if (pop_go) begin
          state_nxt = bdq_pkg::S_READ;
        end
      end
      bdq_pkg::S_READ: begin
        state_nxt = bdq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bdq_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: take a word only when the result register is free at this edge
  always_comb begin
    in_ready = 1'b0;
    case (state_r)
      bdq_pkg::S_IDLE: begin
        in_ready = !out_valid_r || out_ready;
      end
      bdq_pkg::S_READ: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bdq_pkg::S_READ) begin
        out_valid_r <= 1'b1;
      end else if (in_acc && !ctl.rd_en) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: store data after a pop read, else zero with status
  always_ff @(posedge clk) begin
    if (state_r == bdq_pkg::S_READ) begin
      out_data_r.pop_value <= rdata;
      out_data_r.status    <= bdq_pkg::STAT_DONE;
    end else if (in_acc && !ctl.rd_en) begin
      out_data_r.pop_value <= '0;
      out_data_r.status    <= ctl.status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
